FILE: rtl/core/sha1md_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 digest unit package
// Shared word types, hash constants and the control bundles that pass
// between the sequencer, the message schedule and the round unit.
// ----------------------------------------------------------------------------
package sha1md_pkg;

  localparam int SHA1MD_NWORDS  = 5;
  localparam int SHA1MD_BLKWORDS = 16;

  typedef logic [31:0] word_t;
  typedef word_t [SHA1MD_NWORDS-1:0] hash_arr_t;

  // Initial chaining value, word 0 in the lowest slot.
  localparam hash_arr_t SHA1MD_H0 = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [6:0] SHA1MD_LAST_ROUND = 7'd79;
  localparam logic [6:0] SHA1MD_PHASE1     = 7'd20;
  localparam logic [6:0] SHA1MD_PHASE2     = 7'd40;
  localparam logic [6:0] SHA1MD_PHASE3     = 7'd60;

  localparam word_t SHA1MD_K0 = 32'h5a827999;
  localparam word_t SHA1MD_K1 = 32'h6ed9eba1;
  localparam word_t SHA1MD_K2 = 32'h8f1bbcdc;
  localparam word_t SHA1MD_K3 = 32'hca62c1d6;

  localparam word_t SHA1MD_MARKER = 32'h80000000;

  typedef struct packed {
    logic load;
    logic step;
  } sched_ctrl_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic [6:0] idx;
  } rnd_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/core/sha1md_sched.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 message schedule
// A sixteen-word shift line. Message and padding words shift in during
// loading; during the rounds the expanded word shifts in from fixed taps.
// ----------------------------------------------------------------------------
module sha1md_sched
  import sha1md_pkg::*;
(
  input  wire              clk_i,
  input  wire sched_ctrl_t ctrl_i,
  input  wire word_t       word_i,
  output word_t            w_o
);

  word_t [SHA1MD_BLKWORDS-1:0] w_q;
  word_t mix;
  word_t fb;

  // The oldest word sits in slot 0 and is the one used by the current round.
  assign mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  assign fb  = {mix[30:0], mix[31]};
  assign w_o = w_q[0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      w_q <= {word_i, w_q[SHA1MD_BLKWORDS-1:1]};
    end else if (ctrl_i.step) begin
      w_q <= {fb, w_q[SHA1MD_BLKWORDS-1:1]};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sha1md_round.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 round unit
// Holds the five working registers and applies one compression round per
// step, selecting the boolean function and constant by round number.
// ----------------------------------------------------------------------------
module sha1md_round
  import sha1md_pkg::*;
(
  input  wire            clk_i,
  input  wire rnd_ctrl_t ctrl_i,
  input  wire hash_arr_t cv_i,
  input  wire word_t     w_i,
  output hash_arr_t      wr_o
);

  hash_arr_t wr_q;
  word_t a, b, c, d, e;
  word_t f, k, t;

  assign a = wr_q[0];
  assign b = wr_q[1];
  assign c = wr_q[2];
  assign d = wr_q[3];
  assign e = wr_q[4];

  always_comb begin
    if (ctrl_i.idx < SHA1MD_PHASE1) begin
      f = (b & c) | (~b & d);
      k = SHA1MD_K0;
    end else if (ctrl_i.idx < SHA1MD_PHASE2) begin
      f = b ^ c ^ d;
      k = SHA1MD_K1;
    end else if (ctrl_i.idx < SHA1MD_PHASE3) begin
      f = (b & c) | (b & d) | (c & d);
      k = SHA1MD_K2;
    end else begin
      f = b ^ c ^ d;
      k = SHA1MD_K3;
    end
  end

  assign t = {a[26:0], a[31:27]} + f + e + k + w_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      wr_q <= cv_i;
    end else if (ctrl_i.step) begin
      wr_q <= {d, c, {b[1:0], b[31:2]}, a, t};
    end
  end

  assign wr_o = wr_q;

endmodule
`default_nettype wire

FILE: rtl/core/sha1_message_digest_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 message digest unit
// Hashes a message of big-endian 32-bit words and returns the five-word
// digest, then starts over for the next message.
// ----------------------------------------------------------------------------
// A mid-message word is taken while the unit is idle. Every sixteenth word
// starts a compression on the single round unit: the rounds, then a step to
// fold the result into the chaining value, during which no request is taken.
// After the final word the unit shifts in the 0x80 marker, zero fill and the
// 64-bit bit count one word per cycle (pausing while a compression runs),
// runs one or two more compressions, and then presents the digest words 0 to
// 4 in order, one per accepted output request.
module sha1_message_digest_unit
  import sha1md_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [31:0] message_word, [34:32] valid_bytes, [39:35] zero
  input  wire  [39:0] s_axis_tdata_i,
  // end_of_message
  input  wire         s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  // [31:0] digest_word, [34:32] word_index, [39:35] zero
  output logic [39:0] m_axis_tdata_o,
  // last_word
  output logic        m_axis_tlast_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_e;

  state_e      state_q, state_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [3:0]  wpos_q, wpos_d;
  logic [63:0] total_q, total_d;
  hash_arr_t   cv_q, cv_d;
  logic        marker_q, marker_d;
  logic        lenhi_q, lenhi_d;
  logic        pad_q, pad_d;
  logic        final_q, final_d;
  logic [2:0]  oidx_q, oidx_d;

  sched_ctrl_t sched_ctrl;
  rnd_ctrl_t   rnd_ctrl;
  word_t       shift_word;
  word_t       w_cur;
  hash_arr_t   wr;

  logic        s_acc;
  logic        m_acc;
  word_t       in_word;
  logic [2:0]  in_cnt;
  logic [2:0]  cnt;
  word_t       tail_word;
  logic [63:0] bit_len;

  assign in_word = s_axis_tdata_i[31:0];
  assign in_cnt  = s_axis_tdata_i[34:32];
  assign s_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign m_acc   = m_axis_tvalid_o && m_axis_tready_i;
  assign bit_len = {total_q[60:0], 3'b000};

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tdata_o  = {5'b00000, oidx_q, cv_q[oidx_q]};
  assign m_axis_tlast_o  = (oidx_q == 3'd4);

  // Counts above four on the final word are treated as four.
  assign cnt = (in_cnt > 3'd4) ? 3'd4 : in_cnt;

  // Final partial word: keep the valid leading bytes and place the marker.
  always_comb begin
    case (cnt)
      3'd0:    tail_word = SHA1MD_MARKER;
      3'd1:    tail_word = {in_word[31:24], 24'h800000};
      3'd2:    tail_word = {in_word[31:16], 16'h8000};
      3'd3:    tail_word = {in_word[31:8], 8'h80};
      default: tail_word = in_word;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    rnd_d      = rnd_q;
    wpos_d     = wpos_q;
    total_d    = total_q;
    cv_d       = cv_q;
    marker_d   = marker_q;
    lenhi_d    = lenhi_q;
    pad_d      = pad_q;
    final_d    = final_q;
    oidx_d     = oidx_q;
    sched_ctrl = '0;
    rnd_ctrl   = '0;
    rnd_ctrl.idx = rnd_q;
    shift_word = in_word;

    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          sched_ctrl.load = 1'b1;
          wpos_d = wpos_q + 4'd1;
          if (!s_axis_tlast_i) begin
            total_d = total_q + 64'd4;
          end else begin
            total_d    = total_q + {61'd0, cnt};
            shift_word = tail_word;
            marker_d   = (cnt == 3'd4);
            pad_d      = 1'b1;
            state_d    = ST_PAD;
          end
          if (wpos_q == 4'd15) begin
            rnd_ctrl.load = 1'b1;
            rnd_d   = '0;
            state_d = ST_ROUND;
          end
        end
      end

      ST_PAD: begin
        sched_ctrl.load = 1'b1;
        wpos_d = wpos_q + 4'd1;
        if (marker_q) begin
          shift_word = SHA1MD_MARKER;
          marker_d   = 1'b0;
        end else if (wpos_q == 4'd14) begin
          shift_word = bit_len[63:32];
          lenhi_d    = 1'b1;
        end else if (wpos_q == 4'd15 && lenhi_q) begin
          shift_word = bit_len[31:0];
          final_d    = 1'b1;
        end else begin
          shift_word = '0;
        end
        if (wpos_q == 4'd15) begin
          rnd_ctrl.load = 1'b1;
          rnd_d   = '0;
          state_d = ST_ROUND;
        end
      end

      ST_ROUND: begin
        rnd_ctrl.step   = 1'b1;
        sched_ctrl.step = 1'b1;
        if (rnd_q == SHA1MD_LAST_ROUND) begin
          rnd_d   = '0;
          state_d = ST_ADD;
        end else begin
          rnd_d = rnd_q + 7'd1;
        end
      end

      ST_ADD: begin
        for (int i = 0; i < SHA1MD_NWORDS; i++) begin
          cv_d[i] = cv_q[i] + wr[i];
        end
        if (final_q) begin
          oidx_d  = '0;
          state_d = ST_OUT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_OUT: begin
        if (m_acc) begin
          if (oidx_q == 3'd4) begin
            cv_d     = SHA1MD_H0;
            total_d  = '0;
            wpos_d   = '0;
            marker_d = 1'b0;
            lenhi_d  = 1'b0;
            pad_d    = 1'b0;
            final_d  = 1'b0;
            oidx_d   = '0;
            state_d  = ST_IDLE;
          end else begin
            oidx_d = oidx_q + 3'd1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rnd_q    <= '0;
      wpos_q   <= '0;
      total_q  <= '0;
      cv_q     <= SHA1MD_H0;
      marker_q <= 1'b0;
      lenhi_q  <= 1'b0;
      pad_q    <= 1'b0;
      final_q  <= 1'b0;
      oidx_q   <= '0;
    end else begin
      state_q  <= state_d;
      rnd_q    <= rnd_d;
      wpos_q   <= wpos_d;
      total_q  <= total_d;
      cv_q     <= cv_d;
      marker_q <= marker_d;
      lenhi_q  <= lenhi_d;
      pad_q    <= pad_d;
      final_q  <= final_d;
      oidx_q   <= oidx_d;
    end
  end

  sha1md_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .word_i (shift_word),
    .w_o    (w_cur)
  );

  sha1md_round u_round (
    .clk_i  (clk_i),
    .ctrl_i (rnd_ctrl),
    .cv_i   (cv_q),
    .w_i    (w_cur),
    .wr_o   (wr)
  );

`ifndef SYNTHESIS
  a_last_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tlast_i) |=> !s_axis_tready_o)
    else $error("final request did not close the input");

  a_round_to_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && rnd_q == SHA1MD_LAST_ROUND) |=> (state_q == ST_ADD))
    else $error("compression did not end after the last round");

  a_digest_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_acc && m_axis_tlast_o) |=> (s_axis_tready_o && wpos_q == 4'd0 && total_q == 64'd0))
    else $error("unit not cleared after the digest");

  a_idle_round_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_ROUND) |-> (rnd_q == 7'd0))
    else $error("round counter not at zero outside compression");

  a_out_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (oidx_q <= 3'd4))
    else $error("digest word index out of range");
`endif

endmodule
`default_nettype wire
